FILE: hw/rtl/upd_pkg.sv
// Shared types, constants and helpers for the URL percent decoder.
package upd_pkg;

	localparam logic [7:0]  CharPercent    = 8'h25;
	localparam logic [7:0]  CharZero       = 8'h30;
	localparam logic [7:0]  CharNine       = 8'h39;
	localparam logic [7:0]  CharLowerA     = 8'h61;
	localparam logic [7:0]  CharLowerF     = 8'h66;
	localparam logic [7:0]  CaseBit        = 8'h20;
	localparam logic [7:0]  HexAlphaBase   = 8'd10;
	localparam int          MaxBytes       = 3;
	localparam int          QueueDepthDef  = 4;
	localparam logic [15:0] OutLimitReset  = 16'd31;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One decoded item: the kept bytes in order, then an optional terminator.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [1:0]               nkeep;
		logic                     term;
	} bundle_t;

	// Returns {valid, nibble} for a hex digit character of either case.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] v;
		lc = c | CaseBit;
		v = '0;
		if (c >= CharZero && c <= CharNine) begin
			v = c - CharZero;
			return {1'b1, v[3:0]};
		end else if (lc >= CharLowerA && lc <= CharLowerF) begin
			v = lc - CharLowerA + HexAlphaBase;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

FILE: hw/rtl/upd_front.sv
// Front end: escape tracking, limit bookkeeping and bundling of one item's results.
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              bundle_valid,
	output upd_pkg::bundle_t  bundle
);

	logic [15:0]             limit_q;
	upd_pkg::phase_t         phase_q;
	logic [7:0]              held_q;
	logic [15:0]             count_q;

	upd_pkg::phase_t         phase_n;
	logic [7:0]              held_n;
	logic [15:0]             count_n;
	logic [upd_pkg::MaxBytes-1:0][7:0] cand;
	logic [1:0]              ncand;
	logic [1:0]              nkeep;
	logic [15:0]             avail;
	logic [4:0]              hx;
	logic [4:0]              hh;
	logic                    idle_c;

	always_comb begin
		cand = '0;
		ncand = '0;
		phase_n = phase_q;
		held_n = held_q;
		idle_c = 1'b1;
		hx = upd_pkg::hex_decode(in_byte);
		hh = upd_pkg::hex_decode(held_q);
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (hx[4]) begin
					idle_c = 1'b0;
					held_n = in_byte;
					phase_n = upd_pkg::PH_DIGIT;
				end else begin
					cand[ncand] = upd_pkg::CharPercent;
					ncand = ncand + 2'd1;
				end
			end
			upd_pkg::PH_DIGIT: begin
				if (hx[4]) begin
					idle_c = 1'b0;
					cand[ncand] = {hh[3:0], hx[3:0]};
					ncand = ncand + 2'd1;
					phase_n = upd_pkg::PH_NONE;
				end else begin
					cand[ncand] = upd_pkg::CharPercent;
					ncand = ncand + 2'd1;
					cand[ncand] = held_q;
					ncand = ncand + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (idle_c) begin
			if (in_byte == upd_pkg::CharPercent) begin
				phase_n = upd_pkg::PH_PCT;
			end else begin
				cand[ncand] = in_byte;
				ncand = ncand + 2'd1;
				phase_n = upd_pkg::PH_NONE;
			end
		end
		// At string end a held escape is flushed unchanged.
		if (in_last) begin
			case (phase_n)
				upd_pkg::PH_PCT: begin
					cand[ncand] = upd_pkg::CharPercent;
					ncand = ncand + 2'd1;
				end
				upd_pkg::PH_DIGIT: begin
					cand[ncand] = upd_pkg::CharPercent;
					ncand = ncand + 2'd1;
					cand[ncand] = held_n;
					ncand = ncand + 2'd1;
				end
				default: begin
				end
			endcase
			phase_n = upd_pkg::PH_NONE;
		end

		// Emission is a prefix of the candidates, cut at the byte limit.
		avail = limit_q - count_q;
		if (count_q >= limit_q) begin
			nkeep = '0;
		end else if (avail >= {14'd0, ncand}) begin
			nkeep = ncand;
		end else begin
			nkeep = avail[1:0];
		end
		count_n = in_last ? '0 : count_q + {14'd0, nkeep};

		bundle.bytes = cand;
		bundle.nkeep = nkeep;
		bundle.term = in_last;
		bundle_valid = accept && ((nkeep != 2'd0) || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= upd_pkg::OutLimitReset;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_NONE;
			held_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			held_q <= held_n;
			count_q <= count_n;
		end
	end

endmodule

FILE: hw/rtl/upd_queue.sv
// Short bundle queue between the front end and the result serializer.
module upd_queue #(
	parameter int Depth = upd_pkg::QueueDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  upd_pkg::bundle_t wr_data,
	input  logic             rd,
	output logic             full,
	output logic             rd_valid,
	output upd_pkg::bundle_t rd_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	upd_pkg::bundle_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;

	assign full = (cnt_q == CntW'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/upd_back.sv
// Back end: walks each bundle one result at a time into the output register.
module upd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  upd_pkg::bundle_t q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       last_q;

	logic       load;
	logic       final_res;
	logic [2:0] total;
	logic [7:0] sel_byte;

	always_comb begin
		total = {1'b0, q_data.nkeep} + {2'd0, q_data.term};
		final_res = ({1'b0, idx_q} + 3'd1) == total;
		load = q_valid && (!out_valid_q || pop);
		q_rd = load && final_res;
		case (idx_q)
			2'd0: sel_byte = q_data.bytes[0];
			2'd1: sel_byte = q_data.bytes[1];
			2'd2: sel_byte = q_data.bytes[2];
			default: sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_res ? '0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (idx_q < q_data.nkeep) begin
				byte_q <= sel_byte;
				has_q <= 1'b1;
				last_q <= 1'b0;
			end else begin
				byte_q <= '0;
				has_q <= 1'b0;
				last_q <= 1'b1;
			end
		end
	end

	assign empty = !out_valid_q;
	assign out_byte = byte_q;
	assign has_byte = has_q;
	assign out_last = last_q;

endmodule

FILE: hw/rtl/url_percent_decoder.sv
// Top level of the URL percent decoder: front end, bundle queue and result serializer.
// Usage:
// Input side is a queue write port: a byte and its end-of-string flag are taken as a
// transaction at a clock edge with push high and full low. Result side is a queue
// read port: while empty is low the oldest result sits on out_byte, has_byte and
// out_last, and it leaves at an edge with pop high.
// Each byte yields zero to three decoded bytes; a string-end byte adds a terminator
// result (has_byte low, out_last high). The cfg_we/cfg_wdata port sets the most
// decoded bytes kept per string; write it only while the block is idle.
// A transaction's results are written to the bundle queue at the accepting edge and
// move on into the output register as soon as it is free to load.
// Throughput: one input per cycle while each yields at most one result. The
// serializer moves one result per cycle while pop keeps up, so an input with more
// than one result holds it until all have moved; the bundle queue of QueueDepth
// entries absorbs those bursts, and full rises only when it is filled. A stalled pop
// holds the output register, backs up the queue and then raises full; nothing is lost.
// Reset clears escape state, counts and the queue, empties the output register, and
// sets the byte limit to 31.
module url_percent_decoder #(
	parameter int QueueDepth = upd_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        out_last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic             accept;
	logic             q_wr;
	logic             q_rd;
	logic             q_valid;
	upd_pkg::bundle_t wr_bundle;
	upd_pkg::bundle_t rd_bundle;

	assign accept = push && !full;

	upd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.bundle_valid (q_wr),
		.bundle       (wr_bundle)
	);

	upd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (wr_bundle),
		.rd       (q_rd),
		.full     (full),
		.rd_valid (q_valid),
		.rd_data  (rd_bundle)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (rd_bundle),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.has_byte (has_byte),
		.out_last (out_last)
	);

`ifndef SYNTH
	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !has_byte |-> out_last && out_byte == 8'd0)
		else $error("terminator result carries a byte");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid)
		else $error("queue full without a head bundle");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		empty && q_valid |=> !empty)
		else $error("output register not refilled from a waiting bundle");
`endif

endmodule
